FILE: rtl/core/block_cache_lru_range_read_top_macros.svh
// Assertion macros used by the block cache top level.
`ifndef BLOCK_CACHE_LRU_RANGE_READ_TOP_MACROS_SVH
`define BLOCK_CACHE_LRU_RANGE_READ_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BLCR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BLCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/blcr_pkg.sv
// Types and fixed widths shared by the block cache modules.
package blcr_pkg;

  localparam int POS_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int STAMP_W = 32;
  localparam int MAX_OUT = 16;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CSCAN = 5'b00010,
    S_COPY  = 5'b00100,
    S_RSCAN = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  typedef enum logic {
    CMP_LESS  = 1'b0,
    CMP_COVER = 1'b1
  } cmp_op_t;

  typedef struct packed {
    cmp_op_t              op;
    logic [STAMP_W-1:0]   a;
    logic [POS_W-1:0]     b;
    logic [LEN_W-1:0]     len;
  } cmp_req_t;

endpackage

FILE: rtl/core/block_cache_lru_range_read_top.sv
// Top level of the fully associative block cache with LRU replacement.
//
// Usage: one command transfer is taken at a rising edge with start high and
// busy low. in_func = 0 pushes one byte of a block (in_position of the first
// byte is the block start, in_push_last closes the run); in_func = 1 reads
// in_read_length bytes from in_position. A push byte without commit leaves
// busy low. A closing byte that completes exactly BLOCK_BYTES bytes starts
// a commit: a scan of the slots, one per cycle, for the first free slot or
// the oldest stamp, then a copy of the staged bytes, one per cycle; busy
// stays high until the copy is done.
// A read scans the slot start positions one per cycle through the shared
// compare unit. A hit in slot i returns read_length results on consecutive
// cycles; a miss gives one result once the scan has passed the last slot,
// or on the next cycle for a bad length.
// Each result shows for exactly one cycle with out_valid high; the receiver
// cannot stall, so nothing is held back. Reset (rst_n low, synchronous)
// empties the store, the staging run and the use counter; the memories
// need no clearing pass.
`include "block_cache_lru_range_read_top_macros.svh"

module block_cache_lru_range_read_top #(
  parameter int BLOCK_BYTES    = 16,
  parameter int RESERVE_BLOCKS = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [blcr_pkg::POS_W-1:0]  in_position,
  input  logic [blcr_pkg::BYTE_W-1:0] in_push_byte,
  input  logic                        in_push_last,
  input  logic [blcr_pkg::LEN_W-1:0]  in_read_length,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [blcr_pkg::BYTE_W-1:0] out_data_byte,
  output logic                        out_last
);

  localparam int SLOTS  = RESERVE_BLOCKS + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SCNT_W = $clog2(SLOTS + 1);
  localparam int OFF_W  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
  localparam int SC_W   = $clog2(BLOCK_BYTES + 2);
  localparam int DEPTH  = SLOTS * BLOCK_BYTES;
  localparam int DA_W   = $clog2(DEPTH);
  localparam int POS_W  = blcr_pkg::POS_W;
  localparam int BYTE_W = blcr_pkg::BYTE_W;
  localparam int LEN_W  = blcr_pkg::LEN_W;
  localparam int STW    = blcr_pkg::STAMP_W;

  // Memories
  logic [POS_W-1:0]  start_mem [SLOTS];
  logic [STW-1:0]    stamp_mem [SLOTS];
  logic [BYTE_W-1:0] data_mem  [DEPTH];
  logic [BYTE_W-1:0] stage_mem [BLOCK_BYTES];

  // Control state
  blcr_pkg::state_t   state_r, state_nxt;
  logic [SCNT_W-1:0]  issue_r, issue_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [SLOT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [STW-1:0]     best_stamp_r, best_stamp_nxt;
  logic [SLOT_W-1:0]  best_idx_r, best_idx_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SC_W-1:0]    stage_cnt_r, stage_cnt_nxt;
  logic [POS_W-1:0]   stage_start_r, stage_start_nxt;
  logic [STW-1:0]     use_clock_r, use_clock_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [DA_W-1:0]    base_r, base_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   copy_issue_r, copy_issue_nxt;
  logic               wr_v_r, wr_v_nxt;
  logic [OFF_W-1:0]   wr_k_r, wr_k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_last_r, out_last_nxt;

  // Memory read registers
  logic [POS_W-1:0]   start_rd_r;
  logic [STW-1:0]     stamp_rd_r;
  logic [BYTE_W-1:0]  stage_rd_r;
  logic [BYTE_W-1:0]  data_rd_r;

  // Memory port controls
  logic               stage_we;
  logic [OFF_W-1:0]   stage_waddr;
  logic [OFF_W-1:0]   stage_raddr;
  logic               start_we;
  logic               stamp_we;
  logic [SLOT_W-1:0]  stamp_waddr;
  logic [SLOT_W-1:0]  scan_raddr;
  logic               data_we;
  logic [DA_W-1:0]    data_waddr;
  logic [DA_W-1:0]    data_raddr;

  // Shared compare unit
  blcr_pkg::cmp_req_t cmp_req;
  logic               cmp_res;

  logic [SC_W-1:0]    cnt_inc;
  logic               len_ok;
  logic               take;
  logic [OFF_W-1:0]   off;
  logic               last_k;

  blcr_cmp #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_cmp (
    .req    (cmp_req),
    .result (cmp_res)
  );

  assign busy          = (state_r != blcr_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_last      = out_last_r;
  assign out_data_byte = out_hit_r ? data_rd_r : '0;

  assign scan_raddr  = issue_r[SLOT_W-1:0];
  assign stage_raddr = copy_issue_r[OFF_W-1:0];
  assign data_raddr  = base_r + DA_W'(k_r);
  assign data_waddr  = DA_W'(slot_r) * DA_W'(BLOCK_BYTES) + DA_W'(wr_k_r);

  // Staging count saturates at BLOCK_BYTES + 1
  assign cnt_inc = (stage_cnt_r <= SC_W'(BLOCK_BYTES)) ? stage_cnt_r + SC_W'(1) : stage_cnt_r;
  assign len_ok  = (in_read_length != '0) &&
                   (32'(in_read_length) <= 32'(blcr_pkg::MAX_OUT)) &&
                   (32'(in_read_length) <= 32'(BLOCK_BYTES));
  // Offset inside the block is below BLOCK_BYTES, so low bits suffice
  assign off     = pos_r[OFF_W-1:0] - start_rd_r[OFF_W-1:0];
  assign take    = (cmp_idx_r == '0) || cmp_res;
  assign last_k  = ((k_r + LEN_W'(1)) == len_r);

  always_comb begin
    cmp_req.op  = (state_r == blcr_pkg::S_RSCAN) ? blcr_pkg::CMP_COVER : blcr_pkg::CMP_LESS;
    cmp_req.a   = (state_r == blcr_pkg::S_RSCAN) ? start_rd_r : stamp_rd_r;
    cmp_req.b   = (state_r == blcr_pkg::S_RSCAN) ? pos_r : best_stamp_r;
    cmp_req.len = len_r;
  end

  always_comb begin
    state_nxt       = state_r;
    issue_nxt       = issue_r;
    cmp_v_nxt       = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    best_stamp_nxt  = best_stamp_r;
    best_idx_nxt    = best_idx_r;
    slot_nxt        = slot_r;
    stage_cnt_nxt   = stage_cnt_r;
    stage_start_nxt = stage_start_r;
    use_clock_nxt   = use_clock_r;
    valid_nxt       = valid_r;
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    base_nxt        = base_r;
    k_nxt           = k_r;
    copy_issue_nxt  = copy_issue_r;
    wr_v_nxt        = 1'b0;
    wr_k_nxt        = wr_k_r;
    out_valid_nxt   = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_last_nxt    = out_last_r;
    stage_we        = 1'b0;
    stage_waddr     = stage_cnt_r[OFF_W-1:0];
    start_we        = 1'b0;
    stamp_we        = 1'b0;
    stamp_waddr     = slot_r;
    data_we         = 1'b0;

    unique case (state_r)
      blcr_pkg::S_IDLE: begin
        if (start) begin
          issue_nxt = '0;
          if (!in_func) begin
            // push one byte into the staging run
            if (stage_cnt_r == '0) stage_start_nxt = in_position;
            if (stage_cnt_r < SC_W'(BLOCK_BYTES)) stage_we = 1'b1;
            if (in_push_last) begin
              stage_cnt_nxt = '0;
              if (cnt_inc == SC_W'(BLOCK_BYTES)) state_nxt = blcr_pkg::S_CSCAN;
            end else begin
              stage_cnt_nxt = cnt_inc;
            end
          end else begin
            pos_nxt = in_position;
            len_nxt = in_read_length;
            if (len_ok) begin
              state_nxt = blcr_pkg::S_RSCAN;
            end else begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = 1'b0;
              out_last_nxt  = 1'b1;
            end
          end
        end
      end

      blcr_pkg::S_CSCAN: begin
        if (issue_r < SCNT_W'(SLOTS)) begin
          issue_nxt   = issue_r + SCNT_W'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = issue_r[SLOT_W-1:0];
        end
        if (cmp_v_r) begin
          if (!valid_r[cmp_idx_r]) begin
            // first free slot wins
            slot_nxt       = cmp_idx_r;
            copy_issue_nxt = '0;
            state_nxt      = blcr_pkg::S_COPY;
          end else begin
            if (take) begin
              best_stamp_nxt = stamp_rd_r;
              best_idx_nxt   = cmp_idx_r;
            end
            if (cmp_idx_r == SLOT_W'(SLOTS - 1)) begin
              slot_nxt       = take ? cmp_idx_r : best_idx_r;
              copy_issue_nxt = '0;
              state_nxt      = blcr_pkg::S_COPY;
            end
          end
        end
      end

      blcr_pkg::S_COPY: begin
        if (copy_issue_r < CNT_W'(BLOCK_BYTES)) begin
          copy_issue_nxt = copy_issue_r + CNT_W'(1);
          wr_v_nxt       = 1'b1;
          wr_k_nxt       = copy_issue_r[OFF_W-1:0];
        end
        if (copy_issue_r == '0) begin
          // tag, stamp and valid go in on the first copy cycle
          start_we      = 1'b1;
          stamp_we      = 1'b1;
          valid_nxt     = valid_r | (SLOTS'(1) << slot_r);
          use_clock_nxt = use_clock_r + STW'(1);
        end
        if (wr_v_r) begin
          data_we = 1'b1;
          if (wr_k_r == OFF_W'(BLOCK_BYTES - 1)) state_nxt = blcr_pkg::S_IDLE;
        end
      end

      blcr_pkg::S_RSCAN: begin
        if (issue_r < SCNT_W'(SLOTS)) begin
          issue_nxt   = issue_r + SCNT_W'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = issue_r[SLOT_W-1:0];
        end
        if (cmp_v_r) begin
          if (valid_r[cmp_idx_r] && cmp_res) begin
            stamp_we      = 1'b1;
            stamp_waddr   = cmp_idx_r;
            use_clock_nxt = use_clock_r + STW'(1);
            base_nxt      = DA_W'(cmp_idx_r) * DA_W'(BLOCK_BYTES) + DA_W'(off);
            k_nxt         = '0;
            state_nxt     = blcr_pkg::S_SEND;
          end else if (cmp_idx_r == SLOT_W'(SLOTS - 1)) begin
            out_valid_nxt = 1'b1;
            out_hit_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = blcr_pkg::S_IDLE;
          end
        end
      end

      blcr_pkg::S_SEND: begin
        // data read issued now lands with the strobe next cycle
        out_valid_nxt = 1'b1;
        out_hit_nxt   = 1'b1;
        out_last_nxt  = last_k;
        k_nxt         = k_r + LEN_W'(1);
        if (last_k) state_nxt = blcr_pkg::S_IDLE;
      end

      default: state_nxt = blcr_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= blcr_pkg::S_IDLE;
      cmp_v_r       <= 1'b0;
      wr_v_r        <= 1'b0;
      stage_cnt_r   <= '0;
      stage_start_r <= '0;
      use_clock_r   <= '0;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cmp_v_r       <= cmp_v_nxt;
      wr_v_r        <= wr_v_nxt;
      stage_cnt_r   <= stage_cnt_nxt;
      stage_start_r <= stage_start_nxt;
      use_clock_r   <= use_clock_nxt;
      valid_r       <= valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    issue_r      <= issue_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_idx_r   <= best_idx_nxt;
    slot_r       <= slot_nxt;
    pos_r        <= pos_nxt;
    len_r        <= len_nxt;
    base_r       <= base_nxt;
    k_r          <= k_nxt;
    copy_issue_r <= copy_issue_nxt;
    wr_k_r       <= wr_k_nxt;
    out_hit_r    <= out_hit_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Staging buffer
  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[stage_waddr] <= in_push_byte;
    stage_rd_r <= stage_mem[stage_raddr];
  end

  // Block start tags
  always_ff @(posedge clk) begin
    if (start_we) start_mem[slot_r] <= stage_start_r;
    start_rd_r <= start_mem[scan_raddr];
  end

  // Last-use stamps
  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[stamp_waddr] <= use_clock_r;
    stamp_rd_r <= stamp_mem[scan_raddr];
  end

  // Block data
  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_waddr] <= stage_rd_r;
    data_rd_r <= data_mem[data_raddr];
  end

  `BLCR_ASSERT_SAME(a_miss_single, out_valid_r && !out_hit_r, out_last_r && (out_data_byte == '0), "miss result not a single zero last")
  `BLCR_ASSERT_NEXT(a_send_strobe, state_r == blcr_pkg::S_SEND, out_valid_r, "send cycle without result strobe")
  `BLCR_ASSERT_NEXT(a_valid_sticky, 1'b1, (valid_r & $past(valid_r)) == $past(valid_r), "valid slot lost")
  `BLCR_ASSERT_NEXT(a_commit_tick, (state_r == blcr_pkg::S_COPY) && (copy_issue_r == '0), use_clock_r == $past(use_clock_r) + STW'(1), "commit did not advance use clock")

endmodule

FILE: rtl/core/blcr_cmp.sv
// Shared compare unit: stamp less-than or range coverage test.
module blcr_cmp #(
  parameter int BLOCK_BYTES = 16
) (
  input  blcr_pkg::cmp_req_t req,
  output logic               result
);

  localparam int SUM_W = blcr_pkg::POS_W + 1;

  logic [SUM_W-1:0] want_end;
  logic [SUM_W-1:0] have_end;

  // 33-bit sums, no wrap
  assign want_end = {1'b0, req.b} + SUM_W'(req.len);
  assign have_end = {1'b0, req.a} + SUM_W'(BLOCK_BYTES);

  always_comb begin
    unique case (req.op)
      blcr_pkg::CMP_LESS:  result = (req.a < req.b);
      blcr_pkg::CMP_COVER: result = (req.a <= req.b) && (want_end <= have_end);
      default:             result = 1'b0;
    endcase
  end

endmodule

FILE: tb/tb_block_cache_lru_range_read_top.sv
`timescale 1ns / 1ps

// Self-checking testbench for the LRU block cache: push/read traffic against a cache predictor.
module tb_block_cache_lru_range_read_top;

  localparam int BLK     = 16;
  localparam int RESERVE = 15;
  localparam int SLOTS   = RESERVE + 1;

  // Command codes carried on in_func.
  localparam bit FUNC_PUSH = 1'b0;
  localparam bit FUNC_READ = 1'b1;

  // Cycles with no transfer on either side before the run is declared hung.
  // The longest busy stretch is a full commit; sender gaps at 63% idle are short
  // geometric runs, so this leaves a wide margin.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last read beat: covers a trailing commit.
  localparam int DRAIN_TAIL  = 2 * (SLOTS + BLK + 3);
  localparam int MAX_REPORTS = 200;

  // One command transfer plus the pacing that goes with it.
  typedef struct {
    bit                        func;
    bit [blcr_pkg::POS_W-1:0]  pos;
    bit [blcr_pkg::BYTE_W-1:0] push_data;
    bit                        push_last;
    bit [blcr_pkg::LEN_W-1:0]  len;
    int unsigned               idle_pct;  // chance of holding start low per cycle
    bit                        drain;     // hold off until every read beat is back
  } cache_cmd_t;

  // One returned read beat.
  typedef struct {
    bit                        hit;
    bit [blcr_pkg::BYTE_W-1:0] data;
    bit                        last;
  } read_beat_t;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          start          = 1'b0;
  logic                          in_func        = 1'b0;
  logic [blcr_pkg::POS_W-1:0]    in_position    = '0;
  logic [blcr_pkg::BYTE_W-1:0]   in_push_byte   = '0;
  logic                          in_push_last   = 1'b0;
  logic [blcr_pkg::LEN_W-1:0]    in_read_length = '0;
  logic                          busy;
  logic                          out_valid;
  logic                          out_hit;
  logic [blcr_pkg::BYTE_W-1:0]   out_data_byte;
  logic                          out_last;

  block_cache_lru_range_read_top #(
    .BLOCK_BYTES   (BLK),
    .RESERVE_BLOCKS(RESERVE)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_position   (in_position),
    .in_push_byte  (in_push_byte),
    .in_push_last  (in_push_last),
    .in_read_length(in_read_length),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cache predictor. State starts at its reset value (all zero) and is only
  // touched on accepted command transfers.
  // ---------------------------------------------------------------------------
  bit                          line_valid [SLOTS];
  bit [blcr_pkg::POS_W-1:0]    line_base  [SLOTS];
  bit [blcr_pkg::STAMP_W-1:0]  line_stamp [SLOTS];
  bit [blcr_pkg::BYTE_W-1:0]   line_data  [SLOTS][BLK];
  bit [blcr_pkg::BYTE_W-1:0]   fill_data  [BLK];
  int unsigned                 fill_count;
  bit [blcr_pkg::POS_W-1:0]    fill_base;
  bit [blcr_pkg::STAMP_W-1:0]  lru_tick;

  read_beat_t        read_return_q[$];  // beats still owed by the cache, oldest first

  task automatic cache_access(input cache_cmd_t c);
    int              slot;
    int              off;
    longint unsigned lo;
    longint unsigned hi;
    read_beat_t      beat;
    if (c.func == FUNC_PUSH) begin
      // First byte of a run fixes the block start; bytes past BLK are dropped
      // and the count saturates one above BLK.
      if (fill_count == 0) fill_base = c.pos;
      if (fill_count < BLK) fill_data[fill_count] = c.push_data;
      if (fill_count <= BLK) fill_count++;
      if (c.push_last) begin
        if (fill_count == BLK) begin
          // Lowest free slot, else the oldest stamp (lowest slot on a tie).
          slot = -1;
          for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !line_valid[i]) slot = i;
          if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < SLOTS; i++)
              if (line_stamp[i] < line_stamp[slot]) slot = i;
          end
          line_valid[slot] = 1'b1;
          line_base[slot]  = fill_base;
          line_stamp[slot] = lru_tick;
          line_data[slot]  = fill_data;
          lru_tick++;
        end
        fill_count = 0;
      end
    end else begin
      slot = -1;
      if (c.len != 0 && c.len <= blcr_pkg::MAX_OUT && c.len <= BLK) begin
        for (int i = 0; i < SLOTS; i++) begin
          // Coverage is checked with 64-bit sums, so nothing wraps at 2^32.
          lo = line_base[i];
          hi = c.pos;
          hi = hi + c.len;
          if (slot < 0 && line_valid[i] && lo <= c.pos && hi <= lo + BLK) slot = i;
        end
      end
      if (slot < 0) begin
        beat = '{1'b0, '0, 1'b1};
        read_return_q.push_back(beat);
      end else begin
        line_stamp[slot] = lru_tick;
        lru_tick++;
        off = int'(c.pos - line_base[slot]);
        for (int k = 0; k < c.len; k++) begin
          beat.hit  = 1'b1;
          beat.data = line_data[slot][off + k];
          beat.last = (k == c.len - 1);
          read_return_q.push_back(beat);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus queue and the helpers that fill it.
  // ---------------------------------------------------------------------------
  cache_cmd_t                  cmd_q[$];
  bit [blcr_pkg::POS_W-1:0]    base_history[$];  // starts of recently pushed full blocks
  int unsigned                 gen_items;
  int unsigned                 gen_blocks;
  int unsigned                 phase_pct;
  bit                          phase_drain;

  task automatic queue_cmd(input bit func, input bit [blcr_pkg::POS_W-1:0] pos,
                           input bit [blcr_pkg::BYTE_W-1:0] data, input bit last,
                           input bit [blcr_pkg::LEN_W-1:0] len);
    cache_cmd_t c;
    c.func      = func;
    c.pos       = pos;
    c.push_data = data;
    c.push_last = last;
    c.len       = len;
    c.idle_pct  = phase_pct;
    // Occasional full drain on top of the one at each phase boundary.
    c.drain     = phase_drain || ($urandom_range(99) < 2);
    phase_drain = 1'b0;
    cmd_q.push_back(c);
    gen_items++;
  endtask

  // Read with junk on the push-only fields.
  task automatic queue_read(input bit [blcr_pkg::POS_W-1:0] pos,
                            input bit [blcr_pkg::LEN_W-1:0] len);
    queue_cmd(FUNC_READ, pos, blcr_pkg::BYTE_W'($urandom_range(255)),
              1'($urandom_range(1)), len);
  endtask

  // Mostly reads that land on a recent block; some pure noise.
  task automatic queue_random_read();
    bit [blcr_pkg::POS_W-1:0] base;
    int unsigned              off;
    int unsigned              len;
    if (base_history.size() == 0 || $urandom_range(99) < 15) begin
      queue_read($urandom, blcr_pkg::LEN_W'($urandom_range(31)));
    end else begin
      base = base_history[$urandom_range(base_history.size() - 1)];
      off  = $urandom_range(BLK - 1);
      // Usually inside the block; sometimes the tail runs past its end.
      len  = ($urandom_range(9) == 0) ? $urandom_range(BLK, 1) : $urandom_range(BLK - off, 1);
      queue_read(base + off, blcr_pkg::LEN_W'(len));
    end
  endtask

  // A run of nbytes push bytes; only the first position counts, later ones
  // carry junk. Optionally a read lands in the middle of the run.
  task automatic queue_block(input bit [blcr_pkg::POS_W-1:0] base,
                             input int unsigned nbytes, input bit with_read);
    for (int k = 0; k < nbytes; k++) begin
      queue_cmd(FUNC_PUSH, (k == 0) ? base : $urandom,
                blcr_pkg::BYTE_W'($urandom_range(255)),
                k == nbytes - 1, blcr_pkg::LEN_W'($urandom_range(31)));
      if (with_read && k == nbytes / 2) queue_random_read();
    end
    if (nbytes == BLK) begin
      base_history.push_back(base);
      if (base_history.size() > 24) void'(base_history.pop_front());
      gen_blocks++;
    end
  endtask

  // Block starts cluster in a few regions so blocks overlap and reads hit;
  // the top region exercises coverage right at the 2^32 boundary.
  function automatic bit [blcr_pkg::POS_W-1:0] pick_base();
    case ($urandom_range(3))
      0:       pick_base = 32'h0000_0000 + $urandom_range(40);
      1:       pick_base = 32'h8000_0000 + $urandom_range(40);
      2:       pick_base = 32'hFFFF_FFFF - $urandom_range(60);
      default: pick_base = $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: drives at the falling edge, holds an item until its transfer.
  // ---------------------------------------------------------------------------
  int unsigned cmds_issued;
  int unsigned cmds_accepted;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && cmds_accepted != cmds_issued) begin
      // Current command not taken yet: keep it on the bus.
    end else if (cmd_q.size() == 0) begin
      start <= 1'b0;
    end else if (cmd_q[0].drain && (read_return_q.size() != 0 || busy !== 1'b0)) begin
      start <= 1'b0;
    end else if ($urandom_range(99) < cmd_q[0].idle_pct) begin
      start <= 1'b0;
    end else begin
      start          <= 1'b1;
      in_func        <= cmd_q[0].func;
      in_position    <= cmd_q[0].pos;
      in_push_byte   <= cmd_q[0].push_data;
      in_push_last   <= cmd_q[0].push_last;
      in_read_length <= cmd_q[0].len;
      void'(cmd_q.pop_front());
      cmds_issued++;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks read beats and feeds accepted commands to the predictor.
  // ---------------------------------------------------------------------------
  int unsigned mismatches;
  int unsigned stall_cycles;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    read_beat_t want;
    cache_cmd_t taken;
    bit         progress;
    if (rst_n) begin
      progress = 1'b0;
      // Beats are checked before this edge's command is predicted, so a beat
      // can never be matched against a command taken in the same cycle.
      if (out_valid === 1'b1) begin
        progress = 1'b1;
        if (read_return_q.size() == 0) begin
          report_mismatch("read beat with nothing owed", 32'(out_data_byte), '0);
        end else begin
          want = read_return_q.pop_front();
          if (out_hit !== want.hit)
            report_mismatch("hit", 32'(out_hit), 32'(want.hit));
          if (out_data_byte !== want.data)
            report_mismatch("data_byte", 32'(out_data_byte), 32'(want.data));
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
        end
      end
      if (start && busy === 1'b0) begin
        progress        = 1'b1;
        taken.func      = in_func;
        taken.pos       = in_position;
        taken.push_data = in_push_byte;
        taken.push_last = in_push_last;
        taken.len       = in_read_length;
        cache_access(taken);
        cmds_accepted++;
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: too long with no transfer on either side.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pct[3];
    int unsigned phase_start;
    int unsigned roll;
    pct = '{0, 63, 23};

    // Directed: empty-store miss, bad lengths (zero, just over the limit,
    // field max), a full block at the top of the address space carrying
    // bytes 0x00..0xFF, then hits at both ends, a range that would only fit
    // with wraparound, and a low address that no block covers.
    phase_pct   = 0;
    phase_drain = 1'b0;
    queue_read(32'h0000_0000, 5'd1);
    queue_read(32'h0000_0000, 5'd0);
    queue_read(32'hFFFF_FFF0, 5'd17);
    queue_read(32'hFFFF_FFF0, 5'd31);
    for (int k = 0; k < BLK; k++)
      queue_cmd(FUNC_PUSH, (k == 0) ? 32'hFFFF_FFF0 : 32'h0000_0000,
                8'(k * 17), k == BLK - 1, 5'd0);
    base_history.push_back(32'hFFFF_FFF0);
    gen_blocks++;
    queue_read(32'hFFFF_FFF0, 5'd16);
    queue_read(32'hFFFF_FFFF, 5'd1);
    queue_read(32'hFFFF_FFFF, 5'd2);
    queue_read(32'h0000_0000, 5'd1);

    // Random traffic in three pacing phases. Each phase opens with a full
    // drain. The last phase runs until enough full blocks went in to force
    // an eviction.
    for (int ph = 0; ph < 3; ph++) begin
      phase_pct   = pct[ph];
      phase_drain = 1'b1;
      phase_start = gen_items;
      while (gen_items - phase_start < 60 || (ph == 2 && gen_blocks < SLOTS + 1)) begin
        roll = $urandom_range(99);
        if (roll < 65)      queue_block(pick_base(), BLK, $urandom_range(9) == 0);
        else if (roll < 90) queue_random_read();
        else if (roll < 95) queue_block(pick_base(), $urandom_range(BLK - 1, 1), 1'b0);
        else                queue_block(pick_base(), $urandom_range(BLK + 4, BLK + 1), 1'b0);
      end
    end

    // Synchronous reset, released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every command taken, then every read beat back and the cache idle.
    wait (cmd_q.size() == 0 && cmds_accepted == cmds_issued);
    while (read_return_q.size() != 0 || busy !== 1'b0) @(posedge clk);
    // Quiet tail: catches stray beats after the last expected one.
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && read_return_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
